// ===== design/iats_pkg.sv =====
// Shared types and codes for the interface adapter with timers and shift register.
package iats_pkg;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_CB2   = 2'd3;

   localparam logic [3:0] REG_ORB    = 4'd0;
   localparam logic [3:0] REG_ORA    = 4'd1;
   localparam logic [3:0] REG_DDRB   = 4'd2;
   localparam logic [3:0] REG_DDRA   = 4'd3;
   localparam logic [3:0] REG_T1CL   = 4'd4;
   localparam logic [3:0] REG_T1CH   = 4'd5;
   localparam logic [3:0] REG_T1LL   = 4'd6;
   localparam logic [3:0] REG_T1LH   = 4'd7;
   localparam logic [3:0] REG_T2CL   = 4'd8;
   localparam logic [3:0] REG_T2CH   = 4'd9;
   localparam logic [3:0] REG_SR     = 4'd10;
   localparam logic [3:0] REG_ACR    = 4'd11;
   localparam logic [3:0] REG_PCR    = 4'd12;
   localparam logic [3:0] REG_IFR    = 4'd13;
   localparam logic [3:0] REG_IER    = 4'd14;
   localparam logic [3:0] REG_ORA_NH = 4'd15;

   localparam int FLAG_SR  = 2;
   localparam int FLAG_CB2 = 3;
   localparam int FLAG_T2  = 5;
   localparam int FLAG_T1  = 6;

   localparam int ACR_T1_FREE = 6;
   localparam int ACR_PB7_OUT = 7;
   localparam logic [2:0] ACR_SR_IN_T2 = 3'b001;

   localparam logic [3:0] SHIFT_BITS = 4'd8;
   localparam logic [15:0] TIMER_WRAP = 16'hFFFF;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic       chip_select;
      logic       reset_level;
      logic       count_enable;
      logic       cb2_level;
      logic       cb2_quiet;
      logic [7:0] porta_ext;
   } iats_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        handled;
      logic        irq_out;
      logic [4:0]  bank_select;
      logic [7:0]  portb_pins;
      logic [7:0]  porta_pins;
      logic [3:0]  shift_bits_left;
      logic [31:0] shift_count_total;
   } iats_result_type;

   typedef struct packed {
      logic [7:0]  port_b_out;
      logic [7:0]  port_a_out;
      logic [7:0]  dir_b;
      logic [7:0]  dir_a;
      logic [15:0] timer1_count;
      logic [15:0] timer1_latch;
      logic [15:0] timer2_count;
      logic [7:0]  timer2_latch_low;
      logic [7:0]  shift_reg;
      logic [7:0]  aux_control;
      logic [7:0]  periph_control;
      logic [6:0]  int_flags;
      logic [6:0]  int_enable;
      logic        timer1_on;
      logic        timer2_on;
      logic        square_bit;
      logic [3:0]  bits_left;
      logic [31:0] shifted_total;
      logic        cb2_now;
      logic        last_reset_level;
   } iats_state_type;

endpackage

// ===== design/interface_adapter_timers_shift_core.sv =====
// Top level of the interface adapter with timers and shift register.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     type, address, data, select, pins, cb2
//   rsp      out        rsp_valid/stall     read data, handled, irq, port pins, shift
//
// One item is accepted per cycle while req_stall is low; its result appears in the result register the next cycle.
// The result comes from a single pass through the register file logic.
// req_stall rises only while a result waits and rsp_stall is high.
// Synchronous reset clears rsp_valid and the adapter state but not result_ff; the reset pin acts through tick items.
module interface_adapter_timers_shift_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic        req_chip_select,
   input  logic        req_reset_level,
   input  logic        req_count_enable,
   input  logic        req_cb2_level,
   input  logic        req_cb2_quiet,
   input  logic [7:0]  req_porta_ext,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_handled,
   output logic        rsp_irq_out,
   output logic [4:0]  rsp_bank_select,
   output logic [7:0]  rsp_portb_pins,
   output logic [7:0]  rsp_porta_pins,
   output logic [3:0]  rsp_shift_bits_left,
   output logic [31:0] rsp_shift_count_total
);
   import iats_pkg::*;

   iats_req_type    req;
   iats_result_type result;
   iats_result_type result_ff;
   logic            rsp_valid_ff;
   logic            accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      req.req_type     = req_type;
      req.reg_addr     = req_reg_addr;
      req.write_data   = req_write_data;
      req.chip_select  = req_chip_select;
      req.reset_level  = req_reset_level;
      req.count_enable = req_count_enable;
      req.cb2_level    = req_cb2_level;
      req.cb2_quiet    = req_cb2_quiet;
      req.porta_ext    = req_porta_ext;
   end

   iats_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = result_ff.read_data;
   assign rsp_handled           = result_ff.handled;
   assign rsp_irq_out           = result_ff.irq_out;
   assign rsp_bank_select       = result_ff.bank_select;
   assign rsp_portb_pins        = result_ff.portb_pins;
   assign rsp_porta_pins        = result_ff.porta_pins;
   assign rsp_shift_bits_left   = result_ff.shift_bits_left;
   assign rsp_shift_count_total = result_ff.shift_count_total;

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result waits");

   a_tick_unclaimed: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_TICK || req_type == REQ_CB2)
      |=> rsp_valid && !rsp_handled)
      else $error("tick or cb2 item claimed");

   a_unclaimed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handled |-> rsp_read_data == 8'h00)
      else $error("read data on unclaimed item");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shift_bits_left <= SHIFT_BITS)
      else $error("shift count out of range");

endmodule

// ===== design/iats_regs.sv =====
// Register file, timers, shift register and interrupt logic; yields the result of one item.
module iats_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  iats_pkg::iats_req_type    req,
   output iats_pkg::iats_result_type result
);
   import iats_pkg::*;

   iats_state_type state_ff;
   iats_state_type state_in;
   logic [7:0]     read_data;
   logic           handled;
   logic           shift_mode;
   logic           irq_now;

   function automatic logic [7:0] portb_value(input iats_state_type s);
      logic [7:0] v;
      v = s.port_b_out & s.dir_b;
      if (s.aux_control[ACR_PB7_OUT]) begin
         v[7] = s.square_bit;
      end
      return v;
   endfunction

   function automatic logic [7:0] porta_value(input iats_state_type s, input logic [7:0] ext);
      return (s.port_a_out & s.dir_a) | (ext & ~s.dir_a);
   endfunction

   assign shift_mode = (state_ff.aux_control[4:2] == ACR_SR_IN_T2);
   assign irq_now    = |(state_ff.int_flags & state_ff.int_enable);

   always_comb begin
      state_in  = state_ff;
      read_data = 8'h00;
      handled   = 1'b0;
      case (req.req_type)
         REQ_READ: begin
            if (req.chip_select) begin
               handled = 1'b1;
               case (req.reg_addr)
                  REG_ORB:             read_data = portb_value(state_ff);
                  REG_ORA, REG_ORA_NH: read_data = porta_value(state_ff, req.porta_ext);
                  REG_DDRB:            read_data = state_ff.dir_b;
                  REG_DDRA:            read_data = state_ff.dir_a;
                  REG_T1CL: begin
                     read_data = state_ff.timer1_count[7:0];
                     state_in.int_flags[FLAG_T1] = 1'b0;
                  end
                  REG_T1CH:            read_data = state_ff.timer1_count[15:8];
                  REG_T1LL:            read_data = state_ff.timer1_latch[7:0];
                  REG_T1LH:            read_data = state_ff.timer1_latch[15:8];
                  REG_T2CL: begin
                     read_data = state_ff.timer2_count[7:0];
                     state_in.int_flags[FLAG_T2] = 1'b0;
                  end
                  REG_T2CH:            read_data = state_ff.timer2_count[15:8];
                  REG_SR: begin
                     read_data = state_ff.shift_reg;
                     state_in.int_flags[FLAG_SR] = 1'b0;
                     if (shift_mode) begin
                        state_in.bits_left = SHIFT_BITS;
                     end
                  end
                  REG_ACR:             read_data = state_ff.aux_control;
                  REG_PCR:             read_data = state_ff.periph_control;
                  REG_IFR:             read_data = {irq_now, state_ff.int_flags};
                  default:             read_data = {1'b1, state_ff.int_enable};
               endcase
            end
         end
         REQ_WRITE: begin
            if (req.chip_select) begin
               handled = 1'b1;
               case (req.reg_addr)
                  REG_ORB:             state_in.port_b_out = req.write_data;
                  REG_ORA, REG_ORA_NH: state_in.port_a_out = req.write_data;
                  REG_DDRB:            state_in.dir_b = req.write_data;
                  REG_DDRA:            state_in.dir_a = req.write_data;
                  REG_T1CL, REG_T1LL:  state_in.timer1_latch[7:0] = req.write_data;
                  REG_T1CH: begin
                     state_in.timer1_latch[15:8] = req.write_data;
                     state_in.timer1_count = {req.write_data, state_ff.timer1_latch[7:0]};
                     state_in.timer1_on = 1'b1;
                     state_in.int_flags[FLAG_T1] = 1'b0;
                     if (state_ff.aux_control[ACR_PB7_OUT]) begin
                        state_in.square_bit = 1'b0;
                     end
                  end
                  REG_T1LH: begin
                     state_in.timer1_latch[15:8] = req.write_data;
                     state_in.int_flags[FLAG_T1] = 1'b0;
                  end
                  REG_T2CL:            state_in.timer2_latch_low = req.write_data;
                  REG_T2CH: begin
                     state_in.timer2_count = {req.write_data, state_ff.timer2_latch_low};
                     state_in.timer2_on = 1'b1;
                     state_in.int_flags[FLAG_T2] = 1'b0;
                  end
                  REG_SR: begin
                     state_in.shift_reg = req.write_data;
                     state_in.int_flags[FLAG_SR] = 1'b0;
                  end
                  REG_ACR:             state_in.aux_control = req.write_data;
                  REG_PCR:             state_in.periph_control = req.write_data;
                  REG_IFR: begin
                     state_in.int_flags = state_ff.int_flags & ~req.write_data[6:0];
                  end
                  default: begin
                     if (req.write_data[7]) begin
                        state_in.int_enable = state_ff.int_enable | req.write_data[6:0];
                     end else begin
                        state_in.int_enable = state_ff.int_enable & ~req.write_data[6:0];
                     end
                  end
               endcase
            end
         end
         REQ_TICK: begin
            if (req.reset_level && !state_ff.last_reset_level) begin
               state_in = '0;
               state_in.cb2_now = state_ff.cb2_now;
               state_in.last_reset_level = req.reset_level;
            end else begin
               state_in.last_reset_level = req.reset_level;
               if (req.count_enable) begin
                  if (state_ff.timer1_on) begin
                     if (state_ff.timer1_count == 16'h0000) begin
                        state_in.int_flags[FLAG_T1] = 1'b1;
                        if (state_ff.aux_control[ACR_T1_FREE]) begin
                           state_in.timer1_count = state_ff.timer1_latch;
                           if (state_ff.aux_control[ACR_PB7_OUT]) begin
                              state_in.square_bit = ~state_ff.square_bit;
                           end
                        end else begin
                           state_in.timer1_on = 1'b0;
                           if (state_ff.aux_control[ACR_PB7_OUT]) begin
                              state_in.square_bit = 1'b1;
                           end
                        end
                     end else begin
                        state_in.timer1_count = state_ff.timer1_count - 16'd1;
                     end
                  end
                  if (state_ff.timer2_on) begin
                     if (state_ff.timer2_count == 16'h0000) begin
                        state_in.int_flags[FLAG_T2] = 1'b1;
                        if (shift_mode) begin
                           if (state_ff.bits_left != 4'd0) begin
                              state_in.shift_reg = {state_ff.shift_reg[6:0], state_ff.cb2_now};
                              state_in.bits_left = state_ff.bits_left - 4'd1;
                              state_in.shifted_total = state_ff.shifted_total + 32'd1;
                              if (state_ff.bits_left == 4'd1) begin
                                 state_in.int_flags[FLAG_SR] = 1'b1;
                              end
                           end
                           state_in.timer2_count = {8'h00, state_ff.timer2_latch_low};
                        end else begin
                           state_in.timer2_count = TIMER_WRAP;
                        end
                     end else begin
                        state_in.timer2_count = state_ff.timer2_count - 16'd1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in.cb2_now = req.cb2_level;
            if (!req.cb2_quiet && (state_ff.periph_control[7:6] == 2'b00)
                && state_ff.cb2_now && !req.cb2_level) begin
               state_in.int_flags[FLAG_CB2] = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      result.read_data         = read_data;
      result.handled           = handled;
      result.irq_out           = |(state_in.int_flags & state_in.int_enable);
      result.bank_select       = state_in.port_b_out[4:0] & state_in.dir_b[4:0];
      result.portb_pins        = portb_value(state_in);
      result.porta_pins        = porta_value(state_in, req.porta_ext);
      result.shift_bits_left   = state_in.bits_left;
      result.shift_count_total = state_in.shifted_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sim/tb_interface_adapter_timers_shift_core.sv =====
// Testbench for interface_adapter_timers_shift_core: queued stimulus, predictor, result checker.
`timescale 1ns / 1ps

module tb_interface_adapter_timers_shift_core;
   import iats_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 850;
   localparam int PRINT_LIMIT  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   iats_req_type drive_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_handled;
   logic        rsp_irq_out;
   logic [4:0]  rsp_bank_select;
   logic [7:0]  rsp_portb_pins;
   logic [7:0]  rsp_porta_pins;
   logic [3:0]  rsp_shift_bits_left;
   logic [31:0] rsp_shift_count_total;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int queued_count = 0;

   iats_req_type    pending_items[$];
   iats_result_type expected_results[$];
   iats_state_type  adapter = '0;

   interface_adapter_timers_shift_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (drive_item.req_type),
      .req_reg_addr          (drive_item.reg_addr),
      .req_write_data        (drive_item.write_data),
      .req_chip_select       (drive_item.chip_select),
      .req_reset_level       (drive_item.reset_level),
      .req_count_enable      (drive_item.count_enable),
      .req_cb2_level         (drive_item.cb2_level),
      .req_cb2_quiet         (drive_item.cb2_quiet),
      .req_porta_ext         (drive_item.porta_ext),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_data         (rsp_read_data),
      .rsp_handled           (rsp_handled),
      .rsp_irq_out           (rsp_irq_out),
      .rsp_bank_select       (rsp_bank_select),
      .rsp_portb_pins        (rsp_portb_pins),
      .rsp_porta_pins        (rsp_porta_pins),
      .rsp_shift_bits_left   (rsp_shift_bits_left),
      .rsp_shift_count_total (rsp_shift_count_total)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic irq_now();
      return |(adapter.int_flags & adapter.int_enable);
   endfunction

   function automatic logic shift_in_active();
      return adapter.aux_control[4:2] == ACR_SR_IN_T2;
   endfunction

   function automatic logic [7:0] portb_now();
      logic [7:0] pins;
      pins = adapter.port_b_out & adapter.dir_b;
      if (adapter.aux_control[ACR_PB7_OUT]) pins[7] = adapter.square_bit;
      return pins;
   endfunction

   function automatic logic [7:0] porta_now(input logic [7:0] ext);
      return (adapter.port_a_out & adapter.dir_a) | (ext & ~adapter.dir_a);
   endfunction

   task automatic step_adapter(input iats_req_type item, output iats_result_type res);
      logic       keep_cb2;
      logic [7:0] driven_b;
      res = '0;
      case (item.req_type)
         REQ_READ: begin
            if (item.chip_select) begin
               res.handled = 1'b1;
               case (item.reg_addr)
                  REG_ORB: res.read_data = portb_now();
                  REG_ORA, REG_ORA_NH: res.read_data = porta_now(item.porta_ext);
                  REG_DDRB: res.read_data = adapter.dir_b;
                  REG_DDRA: res.read_data = adapter.dir_a;
                  REG_T1CL: begin
                     res.read_data = adapter.timer1_count[7:0];
                     adapter.int_flags[FLAG_T1] = 1'b0;
                  end
                  REG_T1CH: res.read_data = adapter.timer1_count[15:8];
                  REG_T1LL: res.read_data = adapter.timer1_latch[7:0];
                  REG_T1LH: res.read_data = adapter.timer1_latch[15:8];
                  REG_T2CL: begin
                     res.read_data = adapter.timer2_count[7:0];
                     adapter.int_flags[FLAG_T2] = 1'b0;
                  end
                  REG_T2CH: res.read_data = adapter.timer2_count[15:8];
                  REG_SR: begin
                     res.read_data = adapter.shift_reg;
                     adapter.int_flags[FLAG_SR] = 1'b0;
                     if (shift_in_active()) adapter.bits_left = SHIFT_BITS;
                  end
                  REG_ACR: res.read_data = adapter.aux_control;
                  REG_PCR: res.read_data = adapter.periph_control;
                  REG_IFR: res.read_data = {irq_now(), adapter.int_flags};
                  default: res.read_data = {1'b1, adapter.int_enable};
               endcase
            end
         end
         REQ_WRITE: begin
            if (item.chip_select) begin
               res.handled = 1'b1;
               case (item.reg_addr)
                  REG_ORB: adapter.port_b_out = item.write_data;
                  REG_ORA, REG_ORA_NH: adapter.port_a_out = item.write_data;
                  REG_DDRB: adapter.dir_b = item.write_data;
                  REG_DDRA: adapter.dir_a = item.write_data;
                  REG_T1CL, REG_T1LL: adapter.timer1_latch[7:0] = item.write_data;
                  REG_T1CH: begin
                     adapter.timer1_latch[15:8] = item.write_data;
                     adapter.timer1_count = adapter.timer1_latch;
                     adapter.timer1_on = 1'b1;
                     adapter.int_flags[FLAG_T1] = 1'b0;
                     if (adapter.aux_control[ACR_PB7_OUT]) adapter.square_bit = 1'b0;
                  end
                  REG_T1LH: begin
                     adapter.timer1_latch[15:8] = item.write_data;
                     adapter.int_flags[FLAG_T1] = 1'b0;
                  end
                  REG_T2CL: adapter.timer2_latch_low = item.write_data;
                  REG_T2CH: begin
                     adapter.timer2_count = {item.write_data, adapter.timer2_latch_low};
                     adapter.timer2_on = 1'b1;
                     adapter.int_flags[FLAG_T2] = 1'b0;
                  end
                  REG_SR: begin
                     adapter.shift_reg = item.write_data;
                     adapter.int_flags[FLAG_SR] = 1'b0;
                  end
                  REG_ACR: adapter.aux_control = item.write_data;
                  REG_PCR: adapter.periph_control = item.write_data;
                  REG_IFR: adapter.int_flags = adapter.int_flags & ~item.write_data[6:0];
                  default: begin
                     if (item.write_data[7])
                        adapter.int_enable = adapter.int_enable | item.write_data[6:0];
                     else
                        adapter.int_enable = adapter.int_enable & ~item.write_data[6:0];
                  end
               endcase
            end
         end
         REQ_TICK: begin
            if (item.reset_level && !adapter.last_reset_level) begin
               keep_cb2 = adapter.cb2_now;
               adapter = '0;
               adapter.cb2_now = keep_cb2;
            end
            adapter.last_reset_level = item.reset_level;
            if (item.count_enable) begin
               if (adapter.timer1_on) begin
                  if (adapter.timer1_count == 16'd0) begin
                     adapter.int_flags[FLAG_T1] = 1'b1;
                     if (adapter.aux_control[ACR_T1_FREE]) begin
                        adapter.timer1_count = adapter.timer1_latch;
                        if (adapter.aux_control[ACR_PB7_OUT])
                           adapter.square_bit = ~adapter.square_bit;
                     end else begin
                        adapter.timer1_on = 1'b0;
                        if (adapter.aux_control[ACR_PB7_OUT]) adapter.square_bit = 1'b1;
                     end
                  end else begin
                     adapter.timer1_count = adapter.timer1_count - 16'd1;
                  end
               end
               if (adapter.timer2_on) begin
                  if (adapter.timer2_count == 16'd0) begin
                     adapter.int_flags[FLAG_T2] = 1'b1;
                     if (shift_in_active()) begin
                        if (adapter.bits_left != 4'd0) begin
                           adapter.shift_reg = {adapter.shift_reg[6:0], adapter.cb2_now};
                           adapter.bits_left = adapter.bits_left - 4'd1;
                           adapter.shifted_total = adapter.shifted_total + 32'd1;
                           if (adapter.bits_left == 4'd0) adapter.int_flags[FLAG_SR] = 1'b1;
                        end
                        adapter.timer2_count = {8'h00, adapter.timer2_latch_low};
                     end else begin
                        adapter.timer2_count = TIMER_WRAP;
                     end
                  end else begin
                     adapter.timer2_count = adapter.timer2_count - 16'd1;
                  end
               end
            end
         end
         default: begin
            if (!item.cb2_quiet && adapter.periph_control[7:6] == 2'b00 &&
                adapter.cb2_now && !item.cb2_level)
               adapter.int_flags[FLAG_CB2] = 1'b1;
            adapter.cb2_now = item.cb2_level;
         end
      endcase
      driven_b = adapter.port_b_out & adapter.dir_b;
      res.irq_out = irq_now();
      res.bank_select = driven_b[4:0];
      res.portb_pins = portb_now();
      res.porta_pins = porta_now(item.porta_ext);
      res.shift_bits_left = adapter.bits_left;
      res.shift_count_total = adapter.shifted_total;
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT)
            $display("%0t rsp_%s mismatch: expected %0h actual %0h", $time, label, want, got);
      end
   endtask

   function automatic iats_req_type make_item(input logic [1:0] kind, input logic [3:0] addr,
                                              input logic [7:0] data);
      iats_req_type item;
      item.req_type = kind;
      item.reg_addr = addr;
      item.write_data = data;
      item.chip_select = 1'b1;
      item.reset_level = 1'b0;
      item.count_enable = 1'b1;
      item.cb2_level = 1'($urandom_range(1));
      item.cb2_quiet = 1'b0;
      item.porta_ext = 8'($urandom_range(255));
      return item;
   endfunction

   task automatic push_item(input iats_req_type item);
      pending_items.push_back(item);
      queued_count++;
   endtask

   task automatic push_write(input logic [3:0] addr, input logic [7:0] data);
      push_item(make_item(REQ_WRITE, addr, data));
   endtask

   task automatic push_read(input logic [3:0] addr);
      push_item(make_item(REQ_READ, addr, 8'($urandom_range(255))));
   endtask

   task automatic push_ticks(input int count);
      iats_req_type item;
      repeat (count) begin
         item = make_item(REQ_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
         item.count_enable = ($urandom_range(15) != 0);
         push_item(item);
      end
   endtask

   task automatic push_cb2(input logic level, input logic quiet);
      iats_req_type item;
      item = make_item(REQ_CB2, 4'($urandom_range(15)), 8'($urandom_range(255)));
      item.cb2_level = level;
      item.cb2_quiet = quiet;
      push_item(item);
   endtask

   task automatic run_scenario();
      iats_req_type item;
      logic [7:0] acr;
      logic [7:0] pcr;
      int pick;
      acr = 8'($urandom_range(255));
      case ($urandom_range(9))
         0, 1, 2: begin
            acr[4:2] = ACR_SR_IN_T2;
            push_write(REG_ACR, acr);
            push_write(REG_T2CL, 8'($urandom_range(3)));
            push_write(REG_T2CH, ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h00);
            if ($urandom_range(2) == 0) push_write(REG_IER, 8'h80 | 8'($urandom_range(255)));
            push_read(REG_SR);
            repeat ($urandom_range(12, 45)) begin
               pick = $urandom_range(9);
               if (pick < 6) push_ticks(1);
               else if (pick < 8) push_cb2(1'($urandom_range(1)), $urandom_range(3) == 0);
               else if (pick == 8) push_read(REG_SR);
               else push_read(REG_IFR);
            end
         end
         3, 4: begin
            push_write(REG_ACR, acr);
            push_write(REG_T1LL, 8'($urandom_range(4)));
            push_write(REG_T1CH, ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h00);
            repeat ($urandom_range(8, 30)) begin
               pick = $urandom_range(9);
               if (pick < 6) push_ticks(1);
               else if (pick == 6) push_read(REG_T1CL);
               else if (pick == 7) push_read(REG_T1CH);
               else if (pick == 8) push_read(REG_ORB);
               else push_write(REG_T1LH, 8'($urandom_range(1)));
            end
         end
         5: begin
            if (acr[4:2] == ACR_SR_IN_T2) acr[4:2] = 3'b000;
            push_write(REG_ACR, acr);
            push_write(REG_T2CL, 8'($urandom_range(5)));
            push_write(REG_T2CH, 8'h00);
            repeat ($urandom_range(8, 25)) begin
               pick = $urandom_range(5);
               if (pick < 3) push_ticks(1);
               else if (pick == 3) push_read(REG_T2CL);
               else if (pick == 4) push_read(REG_T2CH);
               else push_read(REG_IFR);
            end
         end
         6, 7: begin
            repeat ($urandom_range(6, 14)) begin
               case ($urandom_range(5))
                  0: push_write(4'($urandom_range(15)), 8'($urandom_range(255)));
                  1: push_read(4'($urandom_range(15)));
                  2: begin
                     pcr = 8'($urandom_range(255));
                     if ($urandom_range(1)) pcr[7:6] = 2'b00;
                     push_write(REG_PCR, pcr);
                  end
                  3: push_cb2(1'($urandom_range(1)), $urandom_range(3) == 0);
                  4: push_write(REG_IER, 8'($urandom_range(255)));
                  default: push_write(REG_IFR, 8'($urandom_range(255)));
               endcase
            end
         end
         default: begin
            repeat (8) begin
               item.req_type = 2'($urandom_range(3));
               item.reg_addr = 4'($urandom_range(15));
               item.write_data = 8'($urandom_range(255));
               item.chip_select = ($urandom_range(7) != 0);
               item.reset_level = ($urandom_range(5) == 0);
               item.count_enable = 1'($urandom_range(1));
               item.cb2_level = 1'($urandom_range(1));
               item.cb2_quiet = 1'($urandom_range(1));
               item.porta_ext = 8'($urandom_range(255));
               push_item(item);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : driver
      iats_result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            step_adapter(drive_item, predicted);
            expected_results.push_back(predicted);
         end
         if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            drive_item <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      iats_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_LIMIT)
                  $display("%0t unexpected item: expected none actual read_data %0h",
                           $time, rsp_read_data);
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", 32'(want.read_data), 32'(rsp_read_data));
               check_field("handled", 32'(want.handled), 32'(rsp_handled));
               check_field("irq_out", 32'(want.irq_out), 32'(rsp_irq_out));
               check_field("bank_select", 32'(want.bank_select), 32'(rsp_bank_select));
               check_field("portb_pins", 32'(want.portb_pins), 32'(rsp_portb_pins));
               check_field("porta_pins", 32'(want.porta_pins), 32'(rsp_porta_pins));
               check_field("shift_bits_left", 32'(want.shift_bits_left),
                           32'(rsp_shift_bits_left));
               check_field("shift_count_total", want.shift_count_total,
                           rsp_shift_count_total);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[interface_adapter_timers_shift_core] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      iats_req_type item;
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_write(REG_DDRB, 8'hFF);
      push_write(REG_ORB, 8'hA5);
      push_write(REG_DDRA, 8'h0F);
      push_write(REG_ORA, 8'h3C);
      push_read(REG_ORA_NH);
      item = make_item(REQ_WRITE, REG_ORB, 8'h00);
      item.chip_select = 1'b0;
      push_item(item);
      item.req_type = REQ_READ;
      push_item(item);
      push_write(REG_IER, 8'hFF);
      push_write(REG_ACR, 8'hC0);
      push_write(REG_T1LL, 8'h01);
      push_write(REG_T1CH, 8'h00);
      push_ticks(3);
      push_read(REG_T1CL);
      push_write(REG_ACR, 8'h04);
      push_write(REG_T2CH, 8'h00);
      push_read(REG_SR);
      push_cb2(1'b1, 1'b0);
      push_ticks(2);
      push_cb2(1'b0, 1'b0);
      push_ticks(6);
      push_read(REG_IFR);
      push_read(REG_SR);
      push_write(REG_IFR, 8'h7F);
      push_write(REG_IER, 8'h7F);
      push_read(REG_IER);
      item = make_item(REQ_TICK, REG_ORB, 8'h00);
      item.reset_level = 1'b1;
      push_item(item);
      item.reset_level = 1'b0;
      item.count_enable = 1'b0;
      push_item(item);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 81;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 81;
            end
            default: begin
               sender_idle_pct = 38;
               receiver_stall_pct = 38;
            end
         endcase
         target = queued_count + RANDOM_ITEMS / 4;
         while (queued_count < target) run_scenario();
         while (pending_items.size() != 0 || req_valid) @(posedge clock);
      end

      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("[interface_adapter_timers_shift_core] OK");
      else
         $display("[interface_adapter_timers_shift_core] ERROR");
      $finish;
   end

endmodule

// ===== interface_adapter_timers_shift_core.f =====
design/iats_pkg.sv
design/iats_regs.sv
design/interface_adapter_timers_shift_core.sv
sim/tb_interface_adapter_timers_shift_core.sv
